// File: design/pidpi_pkg.sv
// ----------------------------------------------------------------------------
// pidpi_pkg: shared constants and types for the pid controller
// Field widths, register indexes, command and mode codes, and the request
// struct used between the controller and its bit-serial multipliers.
// ----------------------------------------------------------------------------
`default_nettype none

package pidpi_pkg;

  // default datapath format, signed Q16.16
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // fixed field widths on the ports
  localparam int IN_BITS    = 32;
  localparam int OUT_BITS   = 32;
  localparam int GAIN_BITS  = 32;
  localparam int DT_BITS    = 16;
  localparam int DT_FRAC    = 16;
  localparam int LIMIT_BITS = 31;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_P    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_I    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_D    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_TIME = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LIMIT     = 3'd5;

  // reset values of the configuration registers
  localparam logic [DT_BITS-1:0]    STEP_TIME_RST = 16'd655;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RST     = 31'd6553600;

  // command codes
  localparam logic CMD_COMPUTE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  // controller forms
  localparam logic MODE_POSITIONAL  = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

  // start request to a serial multiplier
  typedef struct packed {
    logic start;
    logic dt_scale;  // shift product by the step time fraction, not the data fraction
  } mul_req_t;

endpackage

`default_nettype wire

// File: design/pid_position_incremental.sv
// ----------------------------------------------------------------------------
// pid_position_incremental: positional / incremental pid controller
// Compute items run through bit-serial multipliers (positional ones also a bit-serial divider);
// clear items zero the stored state and return a zero drive.
// ----------------------------------------------------------------------------
// Positional compute items run the serial divider (DATA_WIDTH+16 steps) and then
// the serial multipliers (DATA_WIDTH+2 steps); incremental items use the multipliers
// only, and clear items go straight to the output. A new item is taken only once the
// last result is in the output register, where it waits while the next item is taken.
// Synchronous reset loads register defaults and zero state.
`default_nettype none

module pid_position_incremental #(
  parameter int DATA_WIDTH = pidpi_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidpi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  // configuration write channel
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic [pidpi_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [pidpi_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  // command stream in
  input  wire logic                                     s_axis_tvalid,
  output logic                                          s_axis_tready,
  input  wire logic [pidpi_pkg::IN_BITS-1:0]            s_axis_tdata,  // [31:0] error_in
  input  wire logic                                     s_axis_tuser,  // [0] cmd
  // drive stream out
  output logic                                          m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  output logic [pidpi_pkg::OUT_BITS-1:0]                m_axis_tdata   // [31:0] drive
);

  localparam int W   = DATA_WIDTH;
  localparam int EXT = ((DATA_WIDTH > pidpi_pkg::IN_BITS) ? DATA_WIDTH : pidpi_pkg::IN_BITS) + 1;

  localparam logic signed [W-1:0] DMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] DMIN_W = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_LOAD    = 7'b0000010,
    S_PHASE_A = 7'b0000100,
    S_START_B = 7'b0001000,
    S_PHASE_B = 7'b0010000,
    S_SUM     = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic                                   mode;
  logic signed [pidpi_pkg::GAIN_BITS-1:0] gain_p;
  logic signed [pidpi_pkg::GAIN_BITS-1:0] gain_i;
  logic signed [pidpi_pkg::GAIN_BITS-1:0] gain_d;
  logic [pidpi_pkg::DT_BITS-1:0]          step_time;
  logic [pidpi_pkg::LIMIT_BITS-1:0]       limit;

  // controller state
  logic signed [W-1:0] integral_acc;
  logic signed [W-1:0] last_error;
  logic signed [W-1:0] older_error;
  logic signed [W-1:0] last_drive;

  // per-item working registers
  logic signed [W-1:0] err;
  logic signed [W-1:0] deriv;
  logic signed [W+1:0] sum_acc;

  // combinational helpers
  logic [EXT-1:0]      in_ext;
  logic signed [W-1:0] in_sat;
  logic [EXT-1:0]      lim_ext;
  logic signed [W-1:0] lim_w;
  logic signed [W:0]   d1;
  logic signed [W+1:0] d2;
  logic signed [W:0]   integ_sum;
  logic signed [W+1:0] sum4;
  logic signed [W+1:0] drive_add;
  logic [EXT-1:0]      drive_ext;
  logic                positional;
  logic                out_free;

  // unit connections
  pidpi_pkg::mul_req_t                    mul_p_req;
  pidpi_pkg::mul_req_t                    mul_i_req;
  pidpi_pkg::mul_req_t                    mul_d_req;
  logic signed [pidpi_pkg::GAIN_BITS-1:0] mul_i_a;
  logic signed [W+1:0]                    mul_p_b;
  logic signed [W+1:0]                    mul_i_b;
  logic signed [W+1:0]                    mul_d_b;
  logic                                   mul_p_busy;
  logic                                   mul_i_busy;
  logic                                   mul_d_busy;
  logic signed [W-1:0]                    mul_p_res;
  logic signed [W-1:0]                    mul_i_res;
  logic signed [W-1:0]                    mul_d_res;
  logic                                   div_start;
  logic                                   div_busy;
  logic signed [W-1:0]                    div_res;

  // saturate a value one bit wider than the data range
  function automatic logic signed [W-1:0] sat_w1(input logic signed [W:0] x);
    if (x[W] != x[W-1]) begin
      sat_w1 = x[W] ? DMIN_W : DMAX_W;
    end else begin
      sat_w1 = x[W-1:0];
    end
  endfunction

  // saturate a value two bits wider than the data range
  function automatic logic signed [W-1:0] sat_w2(input logic signed [W+1:0] x);
    if (x[W+1:W-1] == 3'b000 || x[W+1:W-1] == 3'b111) begin
      sat_w2 = x[W-1:0];
    end else begin
      sat_w2 = x[W+1] ? DMIN_W : DMAX_W;
    end
  endfunction

  // clamp to plus or minus the bound
  function automatic logic signed [W-1:0] clamp_lim(input logic signed [W-1:0] x,
                                                   input logic signed [W-1:0] l);
    if (x > l) begin
      clamp_lim = l;
    end else if (x < -l) begin
      clamp_lim = -l;
    end else begin
      clamp_lim = x;
    end
  endfunction

  assign positional = (mode == pidpi_pkg::MODE_POSITIONAL);
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  // error sample saturated into the data range
  always_comb begin
    in_ext = {{(EXT-pidpi_pkg::IN_BITS){s_axis_tdata[pidpi_pkg::IN_BITS-1]}}, s_axis_tdata};
    if (&in_ext[EXT-1:W-1] || ~|in_ext[EXT-1:W-1]) begin
      in_sat = in_ext[W-1:0];
    end else begin
      in_sat = in_ext[EXT-1] ? DMIN_W : DMAX_W;
    end
  end

  // bound reduced to the data range
  always_comb begin
    lim_ext = {{(EXT-pidpi_pkg::LIMIT_BITS){1'b0}}, limit};
    if (|lim_ext[EXT-1:W-1]) begin
      lim_w = DMAX_W;
    end else begin
      lim_w = lim_ext[W-1:0];
    end
  end

  // error differences, exact
  assign d1 = {err[W-1], err} - {last_error[W-1], last_error};
  assign d2 = {{2{err[W-1]}}, err} - {last_error[W-1], last_error, 1'b0}
            + {{2{older_error[W-1]}}, older_error};

  // integral update and term sum
  assign integ_sum = {integral_acc[W-1], integral_acc} + {mul_i_res[W-1], mul_i_res};
  assign drive_add = positional ? '0 : {{2{last_drive[W-1]}}, last_drive};
  assign sum4 = {{2{mul_p_res[W-1]}}, mul_p_res} + {{2{mul_i_res[W-1]}}, mul_i_res}
              + {{2{mul_d_res[W-1]}}, mul_d_res} + drive_add;

  // unit requests and operands
  always_comb begin
    mul_p_req.start    = (state == S_START_B);
    mul_p_req.dt_scale = 1'b0;
    mul_i_req.start    = (state == S_START_B) || ((state == S_LOAD) && positional);
    mul_i_req.dt_scale = (state == S_LOAD);
    mul_d_req.start    = (state == S_START_B);
    mul_d_req.dt_scale = 1'b0;
    div_start          = (state == S_LOAD) && positional;

    mul_p_b = positional ? {{2{err[W-1]}}, err} : {d1[W], d1};
    mul_d_b = positional ? {{2{deriv[W-1]}}, deriv} : d2;
    if (state == S_LOAD) begin
      mul_i_a = $signed(pidpi_pkg::GAIN_BITS'(step_time));
      mul_i_b = {{2{err[W-1]}}, err};
    end else begin
      mul_i_a = gain_i;
      mul_i_b = positional ? {{2{integral_acc[W-1]}}, integral_acc} : {{2{err[W-1]}}, err};
    end
  end

  pidpi_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul_p (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_p_req),
    .a      (gain_p),
    .b      (mul_p_b),
    .busy   (mul_p_busy),
    .result (mul_p_res)
  );

  pidpi_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul_i (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_i_req),
    .a      (mul_i_a),
    .b      (mul_i_b),
    .busy   (mul_i_busy),
    .result (mul_i_res)
  );

  pidpi_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul_d (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_d_req),
    .a      (gain_d),
    .b      (mul_d_b),
    .busy   (mul_d_busy),
    .result (mul_d_res)
  );

  pidpi_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .diff      (sat_w1(d1)),
    .step_time (step_time),
    .busy      (div_busy),
    .result    (div_res)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser == pidpi_pkg::CMD_CLEAR) ? S_OUT : S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = positional ? S_PHASE_A : S_START_B;
      end
      S_PHASE_A: begin
        if (!mul_i_busy && !div_busy) begin
          state_next = S_START_B;
        end
      end
      S_START_B: begin
        state_next = S_PHASE_B;
      end
      S_PHASE_B: begin
        if (!mul_p_busy && !mul_i_busy && !mul_d_busy) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= pidpi_pkg::MODE_POSITIONAL;
      gain_p    <= '0;
      gain_i    <= '0;
      gain_d    <= '0;
      step_time <= pidpi_pkg::STEP_TIME_RST;
      limit     <= pidpi_pkg::LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pidpi_pkg::REG_MODE:      mode      <= cfg_data[0];
        pidpi_pkg::REG_GAIN_P:    gain_p    <= cfg_data;
        pidpi_pkg::REG_GAIN_I:    gain_i    <= cfg_data;
        pidpi_pkg::REG_GAIN_D:    gain_d    <= cfg_data;
        pidpi_pkg::REG_STEP_TIME: step_time <= cfg_data[pidpi_pkg::DT_BITS-1:0];
        pidpi_pkg::REG_LIMIT:     limit     <= cfg_data[pidpi_pkg::LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // controller state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      last_error   <= '0;
      older_error  <= '0;
      last_drive   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tuser == pidpi_pkg::CMD_CLEAR) begin
            integral_acc <= '0;
            last_error   <= '0;
            older_error  <= '0;
            last_drive   <= '0;
          end
        end
        S_PHASE_A: begin
          if (!mul_i_busy && !div_busy) begin
            integral_acc <= clamp_lim(sat_w1(integ_sum), lim_w);
          end
        end
        S_SUM: begin
          last_drive <= clamp_lim(sat_w2(sum_acc), lim_w);
          last_error <= err;
          if (!positional) begin
            older_error <= last_error;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      err <= in_sat;
    end
    if (state == S_PHASE_A && !mul_i_busy && !div_busy) begin
      deriv <= div_res;
    end
    if (state == S_PHASE_B) begin
      sum_acc <= sum4;
    end
  end

  // input side takes a transaction only between items
  assign s_axis_tready = (state == S_IDLE);

  // output register
  assign drive_ext = {{(EXT-W){last_drive[W-1]}}, last_drive};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_axis_tdata <= drive_ext[pidpi_pkg::OUT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: design/pidpi_mul.sv
// ----------------------------------------------------------------------------
// pidpi_mul: bit-serial signed multiplier with shift and saturation
// Sign-magnitude shift-and-add, one multiplier bit per cycle, then the
// product is shifted right (magnitude truncated) and saturated to the data range.
// ----------------------------------------------------------------------------
`default_nettype none

module pidpi_mul #(
  parameter int DATA_WIDTH = pidpi_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidpi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pidpi_pkg::mul_req_t          req,
  input  wire logic signed [pidpi_pkg::GAIN_BITS-1:0] a,
  input  wire logic signed [DATA_WIDTH+1:0] b,
  output logic                              busy,
  output logic signed [DATA_WIDTH-1:0]      result
);

  localparam int W  = DATA_WIDTH;
  localparam int AW = pidpi_pkg::GAIN_BITS;
  localparam int BM = DATA_WIDTH + 2;
  localparam int PW = AW + BM;
  localparam int CW = $clog2(BM + 1);

  localparam logic [PW-1:0] DMAX_P = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] DMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] DMIN_W = {1'b1, {(W-1){1'b0}}};

  logic [PW-1:0] acc;
  logic [AW-1:0] a_mag;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          dt_scale;

  logic [AW-1:0] a_u;
  logic [BM-1:0] b_u;
  logic [AW-1:0] a_abs;
  logic [BM-1:0] b_abs;
  logic [AW:0]   partial;
  logic [PW-1:0] acc_next;
  logic [PW-1:0] shifted;
  logic signed [W-1:0] res_sat;

  // operand magnitudes
  assign a_u   = a;
  assign b_u   = b;
  assign a_abs = a_u[AW-1] ? (~a_u + AW'(1)) : a_u;
  assign b_abs = b_u[BM-1] ? (~b_u + BM'(1)) : b_u;

  // one shift-and-add step, multiplier bits leave at the bottom
  assign partial  = {1'b0, acc[PW-1:BM]} + {1'b0, (acc[0] ? a_mag : AW'(0))};
  assign acc_next = {partial, acc[BM-1:1]};

  // scale and saturate the finished product
  always_comb begin
    shifted = dt_scale ? (acc >> pidpi_pkg::DT_FRAC) : (acc >> FRAC_BITS);
    if (neg) begin
      if (shifted > DMAX_P + PW'(1)) begin
        res_sat = DMIN_W;
      end else begin
        res_sat = ~shifted[W-1:0] + W'(1);
      end
    end else begin
      if (shifted > DMAX_P) begin
        res_sat = DMAX_W;
      end else begin
        res_sat = shifted[W-1:0];
      end
    end
  end

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      a_mag    <= a_abs;
      acc      <= {AW'(0), b_abs};
      cnt      <= CW'(BM);
      neg      <= a_u[AW-1] ^ b_u[BM-1];
      dt_scale <= req.dt_scale;
      busy     <= 1'b1;
    end else if (busy) begin
      if (cnt != '0) begin
        acc <= acc_next;
        cnt <= cnt - CW'(1);
      end else begin
        result <= res_sat;
        busy   <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/pidpi_div.sv
// ----------------------------------------------------------------------------
// pidpi_div: bit-serial derivative divider
// Restoring division of |diff| << 16 by the step time, one quotient bit per
// cycle, then the signed quotient is saturated to the data range.
// ----------------------------------------------------------------------------
`default_nettype none

module pidpi_div #(
  parameter int DATA_WIDTH = pidpi_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [DATA_WIDTH-1:0]       diff,
  input  wire logic [pidpi_pkg::DT_BITS-1:0]      step_time,
  output logic                                    busy,
  output logic signed [DATA_WIDTH-1:0]            result
);

  localparam int W  = DATA_WIDTH;
  localparam int DB = pidpi_pkg::DT_BITS;
  localparam int QW = DATA_WIDTH + pidpi_pkg::DT_FRAC;
  localparam int CW = $clog2(QW + 1);

  localparam logic [QW-1:0] DMAX_Q = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] DMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] DMIN_W = {1'b1, {(W-1){1'b0}}};

  logic [QW-1:0] quo;
  logic [DB-1:0] rem;
  logic [DB-1:0] divisor;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          dzero;

  logic [W-1:0]  diff_u;
  logic [W-1:0]  diff_abs;
  logic [DB:0]   trial;
  logic [DB:0]   trial_sub;
  logic          ge;
  logic signed [W-1:0] res_sat;

  assign diff_u   = diff;
  assign diff_abs = diff_u[W-1] ? (~diff_u + W'(1)) : diff_u;

  // one restoring step; a zero divisor sets every quotient bit
  assign trial     = {rem, quo[QW-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign ge        = (trial >= {1'b0, divisor});

  // sign and saturate the quotient, no difference gives zero
  always_comb begin
    if (dzero) begin
      res_sat = '0;
    end else if (neg) begin
      if (quo > DMAX_Q + QW'(1)) begin
        res_sat = DMIN_W;
      end else begin
        res_sat = ~quo[W-1:0] + W'(1);
      end
    end else begin
      if (quo > DMAX_Q) begin
        res_sat = DMAX_W;
      end else begin
        res_sat = quo[W-1:0];
      end
    end
  end

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      quo     <= {diff_abs, {pidpi_pkg::DT_FRAC{1'b0}}};
      rem     <= '0;
      divisor <= step_time;
      cnt     <= CW'(QW);
      neg     <= diff_u[W-1];
      dzero   <= (diff_u == '0);
      busy    <= 1'b1;
    end else if (busy) begin
      if (cnt != '0) begin
        rem <= ge ? trial_sub[DB-1:0] : trial[DB-1:0];
        quo <= {quo[QW-2:0], ge};
        cnt <= cnt - CW'(1);
      end else begin
        result <= res_sat;
        busy   <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/pid_drive_checker.sv
// ----------------------------------------------------------------------------
// pid_drive_checker: drive predictor and scoreboard for the pid controller
// Watches the configuration channel and both streams, keeps its own copy of
// the registers and loop state, predicts each drive value and compares it
// with the transaction that leaves the block.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_drive_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  input  wire logic                                 cfg_ready,
  input  wire logic [pidpi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [pidpi_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                 s_axis_tvalid,
  input  wire logic                                 s_axis_tready,
  input  wire logic [pidpi_pkg::IN_BITS-1:0]        s_axis_tdata,   // [31:0] error_in
  input  wire logic                                 s_axis_tuser,   // [0] cmd
  input  wire logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  input  wire logic [pidpi_pkg::OUT_BITS-1:0]       m_axis_tdata,   // [31:0] drive
  output int                                        fail_count,
  output int                                        pending
);
  import pidpi_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -WORD_MAX - 1;

  // register copies
  logic   ctl_mode;
  longint kp, ki, kd;
  longint dt;
  longint bound;

  // loop state
  longint integ_acc, err_prev, err_prev2, drive_prev;

  // drive values still to come out of the block
  logic [OUT_BITS-1:0] drive_q [$];
  int                  drives_seen;

  function automatic longint clip_word(input longint x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  // apply a sign to a magnitude and saturate to the word range
  function automatic longint from_mag(input logic neg, input logic [127:0] m);
    if (neg) begin
      if (m > 128'd2147483648) return WORD_MIN;
      return -longint'(m[63:0]);
    end
    if (m > 128'd2147483647) return WORD_MAX;
    return longint'(m[63:0]);
  endfunction

  // exact product, magnitude shifted right (rounds toward zero), saturated
  function automatic longint fixed_mul(input longint a, input longint b, input int sh);
    logic [127:0] ma, mb;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ma = 128'(a < 0 ? -a : a);
    mb = 128'(b < 0 ? -b : b);
    return from_mag(neg, (ma * mb) >> sh);
  endfunction

  // derivative term: (diff << 16) / step time
  function automatic longint rate_of_change(input longint diff);
    longint       d;
    logic [127:0] m;
    d = clip_word(diff);
    if (dt == 0) begin
      if (d > 0) return WORD_MAX;
      if (d < 0) return WORD_MIN;
      return 0;
    end
    m = 128'(d < 0 ? -d : d);
    return from_mag(d < 0, (m << DT_FRAC) / 128'(dt));
  endfunction

  function automatic longint clamp_bound(input longint x);
    longint lim;
    lim = (bound > WORD_MAX) ? WORD_MAX : bound;
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // one controller step, updates the loop state
  function automatic logic [OUT_BITS-1:0] step_drive(input logic cmd,
                                                     input logic [IN_BITS-1:0] raw);
    longint e, integ, deriv, sum, drive;
    if (cmd == CMD_CLEAR) begin
      integ_acc  = 0;
      err_prev   = 0;
      err_prev2  = 0;
      drive_prev = 0;
      return '0;
    end
    e = $signed(raw);
    if (ctl_mode == MODE_POSITIONAL) begin
      integ     = clip_word(integ_acc + fixed_mul(e, dt, DT_FRAC));
      deriv     = rate_of_change(e - err_prev);
      integ_acc = clamp_bound(integ);
      sum = fixed_mul(kp, e, FRAC_BITS_DEF)
          + fixed_mul(ki, integ_acc, FRAC_BITS_DEF)
          + fixed_mul(kd, deriv, FRAC_BITS_DEF);
    end else begin
      sum = drive_prev
          + fixed_mul(kp, e - err_prev, FRAC_BITS_DEF)
          + fixed_mul(ki, e, FRAC_BITS_DEF)
          + fixed_mul(kd, e - 2 * err_prev + err_prev2, FRAC_BITS_DEF);
      err_prev2 = err_prev;
    end
    drive      = clamp_bound(clip_word(sum));
    drive_prev = drive;
    err_prev   = e;
    return drive[OUT_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                 input logic [OUT_BITS-1:0] want);
    $display("%0t drive check error, result %0d: %s, got %h expected %h",
             $time, drives_seen, what, got, want);
    fail_count++;
  endtask

  // watch the channels at every edge
  always @(posedge clk) begin
    if (rst) begin
      ctl_mode    = MODE_POSITIONAL;
      kp          = 0;
      ki          = 0;
      kd          = 0;
      dt          = STEP_TIME_RST;
      bound       = LIMIT_RST;
      integ_acc   = 0;
      err_prev    = 0;
      err_prev2   = 0;
      drive_prev  = 0;
      drives_seen = 0;
      fail_count  = 0;
      drive_q.delete();
      pending <= 0;
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:      ctl_mode = cfg_data[0];
          REG_GAIN_P:    kp = $signed(cfg_data[GAIN_BITS-1:0]);
          REG_GAIN_I:    ki = $signed(cfg_data[GAIN_BITS-1:0]);
          REG_GAIN_D:    kd = $signed(cfg_data[GAIN_BITS-1:0]);
          REG_STEP_TIME: dt = cfg_data[DT_BITS-1:0];
          REG_LIMIT:     bound = cfg_data[LIMIT_BITS-1:0];
          default: ;
        endcase
      end
      // command transaction in
      if (s_axis_tvalid && s_axis_tready)
        drive_q.push_back(step_drive(s_axis_tuser, s_axis_tdata));
      // drive transaction out
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_q.size() == 0)
          report_mismatch("no drive pending", m_axis_tdata, 'x);
        else if (m_axis_tdata !== drive_q[0])
          report_mismatch("drive value", m_axis_tdata, drive_q[0]);
        if (drive_q.size() != 0)
          void'(drive_q.pop_front());
        drives_seen++;
      end
      pending <= drive_q.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/pid_position_incremental_tb.sv
// ----------------------------------------------------------------------------
// pid_position_incremental_tb: testbench top for the pid controller
// Drives a directed set of commands and then random phases with random
// register settings and random idling on both streams; the drive checker
// predicts and compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_position_incremental_tb;
  import pidpi_pkg::*;

  localparam int HANG_LIMIT    = 5000;
  localparam int TAIL_CYCLES   = 120;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 240;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NMAX = 32'h8000_0000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_BITS-1:0]        s_axis_tdata = '0;
  logic                      s_axis_tuser = CMD_COMPUTE;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]       m_axis_tdata;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet     = 0;

  pid_position_incremental dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pid_drive_checker drive_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // hang detection: cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= HANG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] random_sign(input logic [31:0] m);
    return $urandom_range(1) ? -m : m;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(6))
      0, 1, 2: return random_sign($urandom_range(0, 32'h0008_0000));
      3:       return random_sign($urandom_range(0, 32'h0000_FFFF));
      4:       return $urandom;
      5:       return $urandom_range(1) ? PMAX : NMAX;
      default: return '0;
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(9))
      0:          return 32'd0;
      1:          return 32'd1;
      2:          return 32'd65535;
      3, 4, 5, 6: return $urandom_range(1, 65535);
      default:    return $urandom_range(100, 3000);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(6))
      0:       return 32'd0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom & 32'h7FFF_FFFF;
      default: return $urandom_range(32'h0001_0000, 32'h03E8_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_error();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return random_sign($urandom_range(0, 32'h0014_0000));
      5, 6:          return random_sign($urandom_range(0, 32'h1000_0000));
      7:             return $urandom;
      8:             return $urandom_range(1) ? PMAX : NMAX;
      default:       return random_sign($urandom_range(0, 1));
    endcase
  endfunction

  // stop sending and wait for every outstanding drive
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // register writes only once the block is idle
  task automatic apply_settings(input logic mode, input logic [31:0] gp,
                                input logic [31:0] gi, input logic [31:0] gd,
                                input logic [31:0] step, input logic [31:0] lim);
    wait_drained();
    cfg_write(REG_MODE, {31'd0, mode});
    cfg_write(REG_GAIN_P, gp);
    cfg_write(REG_GAIN_I, gi);
    cfg_write(REG_GAIN_D, gd);
    cfg_write(REG_STEP_TIME, step);
    cfg_write(REG_LIMIT, lim);
  endtask

  // one command transaction, then a random sender gap
  task automatic send_item(input logic cmd, input logic [31:0] err);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= err;
    do @(posedge clk); while (!s_axis_tready);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic run_directed();
    // plain gains, sign and range extremes of the error, a clear
    apply_settings(MODE_POSITIONAL, ONE, 32'h8000, 32'h4000, 32'd655, 32'd6553600);
    send_item(CMD_COMPUTE, 32'd0);
    send_item(CMD_COMPUTE, ONE);
    send_item(CMD_COMPUTE, 32'hFFFF_0000);
    send_item(CMD_COMPUTE, PMAX);
    send_item(CMD_COMPUTE, NMAX);
    send_item(CMD_COMPUTE, NMAX);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF);
    send_item(CMD_COMPUTE, 32'h0002_8000);
    // extreme gains, shortest step, widest limit
    apply_settings(MODE_POSITIONAL, PMAX, NMAX, PMAX, 32'd1, 32'h7FFF_FFFF);
    send_item(CMD_COMPUTE, PMAX);
    send_item(CMD_COMPUTE, NMAX);
    send_item(CMD_COMPUTE, 32'd0);
    send_item(CMD_COMPUTE, 32'd1);
    // zero step time: derivative saturates by sign or is zero
    apply_settings(MODE_POSITIONAL, ONE, ONE, ONE, 32'd0, 32'd3276800);
    send_item(CMD_COMPUTE, 32'h0005_0000);
    send_item(CMD_COMPUTE, 32'h0005_0000);
    send_item(CMD_COMPUTE, 32'hFFFD_0000);
    // zero limit, longest step
    apply_settings(MODE_POSITIONAL, NMAX, ONE, NMAX, 32'd65535, 32'd0);
    send_item(CMD_COMPUTE, 32'h0007_0000);
    send_item(CMD_COMPUTE, 32'hFFF9_0000);
    // mode change keeps the stored state
    apply_settings(MODE_POSITIONAL, ONE, ONE, ONE, 32'd655, 32'd6553600);
    send_item(CMD_COMPUTE, 32'h0003_0000);
    send_item(CMD_COMPUTE, 32'hFFFE_0000);
    apply_settings(MODE_INCREMENTAL, ONE, ONE, ONE, 32'd655, 32'd6553600);
    send_item(CMD_COMPUTE, 32'h0004_0000);
    send_item(CMD_COMPUTE, PMAX);
    send_item(CMD_COMPUTE, NMAX);
    send_item(CMD_CLEAR, 32'h0000_0000);
    send_item(CMD_COMPUTE, ONE);
  endtask

  task automatic run_random_phase(input int phase);
    logic mode;
    mode = logic'((phase + phase / 4) % 2);
    idle_pct  = 0;
    stall_pct = 0;
    apply_settings(mode, pick_gain(), pick_gain(), pick_gain(), pick_step(), pick_limit());
    case (phase % 4)
      1:       idle_pct = 84;
      2:       stall_pct = 84;
      3:       begin idle_pct = 30; stall_pct = 30; end
      default: ;
    endcase
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // occasional full pause of the sender mid-phase
      if ($urandom_range(199) == 0)
        wait_drained();
      if ($urandom_range(99) < 3)
        send_item(CMD_CLEAR, $urandom);
      else
        send_item(CMD_COMPUTE, pick_error());
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < PHASES; p++)
      run_random_phase(p);
    wait_drained();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// File: pid_position_incremental.f
design/pidpi_pkg.sv
design/pidpi_mul.sv
design/pidpi_div.sv
design/pid_position_incremental.sv
tb/sv/pid_drive_checker.sv
tb/sv/pid_position_incremental_tb.sv
